// ===== rtl/sev_pkg.sv =====
`timescale 1ns / 1ps

package sev_pkg;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_OVERLAP = 3'd3;
    localparam logic [2:0] ST_NOSPACE = 3'd4;
    localparam logic [2:0] ST_GENOVF  = 3'd5;
    localparam logic [2:0] ST_TOOMANY = 3'd6;
    localparam logic [2:0] ST_ABORTED = 3'd7;

    // Register indexes (byte address bits [4:3]).
    localparam logic [1:0] REG_USER_ORIGIN  = 2'd0;
    localparam logic [1:0] REG_PHYS_ORIGIN  = 2'd1;
    localparam logic [1:0] REG_MAP_SIZE     = 2'd2;
    localparam logic [1:0] REG_OUT_CAPACITY = 2'd3;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    // Configuration values seen by the datapath.
    typedef struct packed {
        logic [63:0] user_origin;
        logic [63:0] phys_origin;
        logic [31:0] map_size;
        logic [31:0] out_capacity;
    } cfg_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_OFFSET,
        S_RANGE,
        S_SCAN,
        S_DECIDE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic offset;
        logic range;
        logic scan;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_busy;
        logic out_busy;
    } sts_t;

endpackage

// ===== rtl/sev_cfg.sv =====
`timescale 1ns / 1ps

module sev_cfg
    import sev_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic        wr_en;
    logic [1:0]  reg_idx;
    logic [63:0] user_origin_reg;
    logic [63:0] phys_origin_reg;
    logic [31:0] map_size_reg;
    logic [31:0] out_capacity_reg;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:3];

    // Register writes on the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_origin_reg  <= '0;
            phys_origin_reg  <= '0;
            map_size_reg     <= '0;
            out_capacity_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_USER_ORIGIN:  user_origin_reg  <= pwdata;
                REG_PHYS_ORIGIN:  phys_origin_reg  <= pwdata;
                REG_MAP_SIZE:     map_size_reg     <= pwdata[31:0];
                REG_OUT_CAPACITY: out_capacity_reg <= pwdata[31:0];
                default:          ;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        case (reg_idx)
            REG_USER_ORIGIN:  prdata = user_origin_reg;
            REG_PHYS_ORIGIN:  prdata = phys_origin_reg;
            REG_MAP_SIZE:     prdata = {32'd0, map_size_reg};
            REG_OUT_CAPACITY: prdata = {32'd0, out_capacity_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.user_origin  = user_origin_reg;
    assign cfg.phys_origin  = phys_origin_reg;
    assign cfg.map_size     = map_size_reg;
    assign cfg.out_capacity = out_capacity_reg;

endmodule

// ===== rtl/sev_ctrl.sv =====
`timescale 1ns / 1ps

module sev_ctrl
    import sev_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_OFFSET;
                end
            end
            S_OFFSET: state_next = S_RANGE;
            S_RANGE:  state_next = S_SCAN;
            S_SCAN:
            begin
                if (!sts.scan_busy)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_OFFSET: cmd.offset = 1'b1;
            S_RANGE:  cmd.range  = 1'b1;
            S_SCAN:   cmd.scan   = 1'b1;
            S_DECIDE: cmd.commit = !sts.out_busy;
            default:  ;
        endcase
    end

endmodule

// ===== rtl/sev_dp.sv =====
`timescale 1ns / 1ps

module sev_dp
    import sev_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [63:0] user_addr,
    input  logic [63:0] phys_addr,
    input  logic [31:0] entry_len,
    input  logic        last_entry,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] src_offset,
    output logic [31:0] dst_offset,
    output logic [31:0] span_len,
    output logic [63:0] generation_out,
    output logic        unit_done
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // Captured item.
    logic [63:0] ua_reg;
    logic [63:0] pa_reg;
    logic [31:0] len_reg;
    logic        last_reg;

    // Offset stage.
    logic [63:0] uoff64_reg;
    logic [63:0] poff64_reg;
    logic        below_reg;

    // Range stage.
    logic [64:0] end65;
    logic        range_bad;
    logic [2:0]  pre_status;
    logic [2:0]  pre_status_reg;
    logic [31:0] uoff_reg;
    logic [31:0] end_reg;

    // Overlap scan.
    logic [31:0]      mem_start [MAX_ENTRIES];
    logic [31:0]      mem_end   [MAX_ENTRIES];
    logic [31:0]      rd_start_reg;
    logic [31:0]      rd_end_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] rd_idx_next;
    logic             cmp_valid_reg;
    logic             cmp_valid_next;
    logic             hit_reg;
    logic             hit_next;
    logic             issue;
    logic             overlap;

    // Unit state.
    logic [CNT_W-1:0] entries_seen_reg;
    logic [CNT_W-1:0] entries_seen_next;
    logic [31:0]      packed_total_reg;
    logic [31:0]      packed_total_next;
    logic [63:0]      gen_reg;
    logic [63:0]      gen_next;
    logic             aborted_reg;
    logic             aborted_next;

    // Decision.
    logic [32:0] next_total;
    logic [2:0]  final_status;
    logic        ok;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [2:0]  status_reg;
    logic [31:0] src_offset_reg;
    logic [31:0] dst_offset_reg;
    logic [31:0] span_len_reg;
    logic [63:0] gen_out_reg;
    logic        unit_done_reg;

    // Capture the item and compute both offsets.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ua_reg   <= user_addr;
            pa_reg   <= phys_addr;
            len_reg  <= entry_len;
            last_reg <= last_entry;
        end
        if (cmd.offset)
        begin
            uoff64_reg <= ua_reg - cfg.user_origin;
            poff64_reg <= pa_reg - cfg.phys_origin;
            below_reg  <= (ua_reg < cfg.user_origin) || (pa_reg < cfg.phys_origin);
        end
    end

    // Early checks in priority order, before the overlap scan.
    assign end65     = {1'b0, uoff64_reg} + {33'd0, len_reg};
    assign range_bad = below_reg || (uoff64_reg != poff64_reg)
                       || (end65 > {33'd0, cfg.map_size});

    always_comb
    begin
        if (aborted_reg)
        begin
            pre_status = ST_ABORTED;
        end
        else if (entries_seen_reg >= CNT_W'(MAX_ENTRIES))
        begin
            pre_status = ST_TOOMANY;
        end
        else if (len_reg == 32'd0)
        begin
            pre_status = ST_ZERO;
        end
        else if (range_bad)
        begin
            pre_status = ST_RANGE;
        end
        else
        begin
            pre_status = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.range)
        begin
            pre_status_reg <= pre_status;
            uoff_reg       <= uoff64_reg[31:0];
            end_reg        <= end65[31:0];
        end
    end

    // Scan: one stored span is read per cycle and compared the cycle after.
    assign issue   = cmd.scan && (pre_status_reg == ST_OK) && (rd_idx_reg < entries_seen_reg);
    assign overlap = (uoff_reg < rd_end_reg) && (rd_start_reg < end_reg);

    always_comb
    begin
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = issue;
        hit_next       = hit_reg;
        if (cmd.range)
        begin
            rd_idx_next = '0;
            hit_next    = 1'b0;
        end
        else
        begin
            if (issue)
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            if (cmp_valid_reg && overlap)
            begin
                hit_next = 1'b1;
            end
        end
    end

    assign sts.scan_busy = issue || cmp_valid_reg;

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_start_reg <= mem_start[rd_idx_reg[IDX_W-1:0]];
            rd_end_reg   <= mem_end[rd_idx_reg[IDX_W-1:0]];
        end
        if (cmd.commit && ok)
        begin
            mem_start[entries_seen_reg[IDX_W-1:0]] <= uoff_reg;
            mem_end[entries_seen_reg[IDX_W-1:0]]   <= end_reg;
        end
    end

    // Final status: any early check result, then overlap, then space, then generation overflow.
    assign next_total = {1'b0, packed_total_reg} + {1'b0, len_reg};

    always_comb
    begin
        if (pre_status_reg != ST_OK)
        begin
            final_status = pre_status_reg;
        end
        else if (hit_reg)
        begin
            final_status = ST_OVERLAP;
        end
        else if (next_total > {1'b0, cfg.out_capacity})
        begin
            final_status = ST_NOSPACE;
        end
        else if (last_reg && (gen_reg == '1))
        begin
            final_status = ST_GENOVF;
        end
        else
        begin
            final_status = ST_OK;
        end
    end

    assign ok = (final_status == ST_OK);

    // Unit bookkeeping and the output valid flag.
    always_comb
    begin
        entries_seen_next = entries_seen_reg;
        packed_total_next = packed_total_reg;
        gen_next          = gen_reg;
        aborted_next      = aborted_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            if (ok)
            begin
                entries_seen_next = entries_seen_reg + CNT_W'(1);
                packed_total_next = next_total[31:0];
                if (last_reg)
                begin
                    gen_next = gen_reg + 64'd1;
                end
            end
            else
            begin
                aborted_next = 1'b1;
            end
            if (last_reg)
            begin
                entries_seen_next = '0;
                packed_total_next = '0;
                aborted_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg       <= '0;
            cmp_valid_reg    <= 1'b0;
            hit_reg          <= 1'b0;
            entries_seen_reg <= '0;
            packed_total_reg <= '0;
            gen_reg          <= '0;
            aborted_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            rd_idx_reg       <= rd_idx_next;
            cmp_valid_reg    <= cmp_valid_next;
            hit_reg          <= hit_next;
            entries_seen_reg <= entries_seen_next;
            packed_total_reg <= packed_total_next;
            gen_reg          <= gen_next;
            aborted_reg      <= aborted_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg     <= final_status;
            src_offset_reg <= ok ? uoff_reg : 32'd0;
            dst_offset_reg <= ok ? packed_total_reg : 32'd0;
            span_len_reg   <= ok ? len_reg : 32'd0;
            gen_out_reg    <= (ok && last_reg) ? (gen_reg + 64'd1) : 64'd0;
            unit_done_reg  <= last_reg;
        end
    end

    assign sts.out_busy   = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign src_offset     = src_offset_reg;
    assign dst_offset     = dst_offset_reg;
    assign span_len       = span_len_reg;
    assign generation_out = gen_out_reg;
    assign unit_done      = unit_done_reg;

endmodule

// ===== rtl/stream_entry_validator_core.sv =====
`timescale 1ns / 1ps

// Stream entry validator.
// Input channel (in_valid/in_ready) carries one descriptor entry per item:
// user_addr, phys_addr, entry_len and last_entry. The output channel
// (out_valid/out_ready) returns exactly one result item per entry.
// An APB-style port sets the user and physical buffer bases, map_size and
// out_capacity at byte addresses 0, 8, 16 and 24; write it only while the
// block is idle.
// An accepted item is captured, its offsets are computed, the early range
// checks are registered, the overlap scan compares it with any of the N
// entries already accepted in the current unit (1 to MAX_ENTRIES - 1), and
// the decision is registered as its result. The scan reads one stored span
// per cycle from the span memory, so one item is in work at a time and the
// next is taken only after the result is registered. The input is taken
// again even while that result still waits to be taken.
// Reset clears the configuration, the unit state and the generation counter.
// If the receiver stalls, the result holds in the output register and the
// next item waits before its final step until the output is free.

module stream_entry_validator_core
    import sev_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [63:0]       user_addr,
    input  logic [63:0]       phys_addr,
    input  logic [31:0]       entry_len,
    input  logic              last_entry,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [31:0]       src_offset,
    output logic [31:0]       dst_offset,
    output logic [31:0]       span_len,
    output logic [63:0]       generation_out,
    output logic              unit_done
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // Configuration registers.
    sev_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    sev_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Checks, span memory and result register.
    sev_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .user_addr      (user_addr),
        .phys_addr      (phys_addr),
        .entry_len      (entry_len),
        .last_entry     (last_entry),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .src_offset     (src_offset),
        .dst_offset     (dst_offset),
        .span_len       (span_len),
        .generation_out (generation_out),
        .unit_done      (unit_done)
    );

endmodule

// ===== verif/tb_stream_entry_validator_core.sv =====
`timescale 1ns / 1ps

module tb_stream_entry_validator_core
    import sev_pkg::*;
();

    localparam int          MAX_SPANS     = 16;
    localparam int          RANDOM_ITEMS  = 1630;
    localparam int          NUM_SETTINGS  = 8;
    localparam int          SETTLE_CYCLES = 2 * (5 + MAX_SPANS);
    localparam int          LONG_HOLD     = 400;
    localparam int          HOLD_AFTER    = 300;
    localparam int          NUM_PROBES    = 22;
    localparam int          RESET_ROWS    = 3;
    localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] DIR_UB        = 64'h0000_0000_0001_0000;
    localparam logic [63:0] DIR_PB        = 64'h0000_0000_8000_0000;

    // One result item as the block should return it.
    typedef struct packed {
        logic [2:0]  code;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] span;
        logic [63:0] gen;
        logic        done;
    } entry_verdict_t;

    // One directed entry; typed rows carry their error code by hand.
    typedef struct {
        logic [63:0] ua;
        logic [63:0] pa;
        logic [31:0] len;
        logic        last;
        logic        typed;
        logic [2:0]  code;
    } probe_row_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    logic [63:0]       user_addr;
    logic [63:0]       phys_addr;
    logic [31:0]       entry_len;
    logic              last_entry;
    logic              out_valid;
    logic              out_ready;
    logic [2:0]        status;
    logic [31:0]       src_offset;
    logic [31:0]       dst_offset;
    logic [31:0]       span_len;
    logic [63:0]       generation_out;
    logic              unit_done;

    // Register copies as the block should hold them.
    logic [63:0] cfg_user_origin;
    logic [63:0] cfg_phys_origin;
    logic [31:0] cfg_map_size;
    logic [31:0] cfg_out_capacity;

    // Unit state of the predictor.
    logic [31:0] span_start [MAX_SPANS];
    logic [31:0] span_bytes [MAX_SPANS];
    int          spans_held;
    logic [63:0] packed_bytes;
    logic [63:0] gen_count;
    logic        unit_broken;

    entry_verdict_t verdicts_due [$];
    probe_row_t     probe_rows [NUM_PROBES];

    int fail_count;
    int items_sent;
    int units_sent;
    int results_seen;
    int settings_used;
    int burst_left;
    int code_seen [8];

    stream_entry_validator_core #(
        .MAX_ENTRIES(MAX_SPANS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .user_addr     (user_addr),
        .phys_addr     (phys_addr),
        .entry_len     (entry_len),
        .last_entry    (last_entry),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .src_offset    (src_offset),
        .dst_offset    (dst_offset),
        .span_len      (span_len),
        .generation_out(generation_out),
        .unit_done     (unit_done)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The run is cut off if it hangs.
    initial
    begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Validate one entry against the current unit and update the unit state.
    function automatic entry_verdict_t validate_entry(input logic [63:0] ua,
                                                      input logic [63:0] pa,
                                                      input logic [31:0] len,
                                                      input logic        last);
        entry_verdict_t v;
        logic [63:0]    uoff;
        logic [63:0]    end_off;
        logic [63:0]    next_total;
        logic [63:0]    b0;
        logic [63:0]    b1;
        logic [2:0]     code;
        v          = '0;
        code       = ST_OK;
        uoff       = '0;
        end_off    = '0;
        next_total = '0;

        // Gate checks, then the address range in the documented order.
        if (unit_broken)
            code = ST_ABORTED;
        else if (spans_held >= MAX_SPANS)
            code = ST_TOOMANY;
        else if (len == 32'd0)
            code = ST_ZERO;
        else if (ua < cfg_user_origin || pa < cfg_phys_origin)
            code = ST_RANGE;
        else
        begin
            uoff = ua - cfg_user_origin;
            if (uoff != pa - cfg_phys_origin)
                code = ST_RANGE;
            else
            begin
                end_off = uoff + {32'd0, len};
                if (end_off < uoff || end_off > {32'd0, cfg_map_size})
                    code = ST_RANGE;
            end
        end

        // The new span must not overlap any span already taken in this unit.
        if (code == ST_OK)
        begin
            for (int k = 0; k < spans_held; k++)
            begin
                b0 = {32'd0, span_start[k]};
                b1 = b0 + {32'd0, span_bytes[k]};
                if (code == ST_OK && uoff < b1 && b0 < end_off)
                    code = ST_OVERLAP;
            end
        end

        // Packed destination space, then the generation counter.
        if (code == ST_OK)
        begin
            next_total = packed_bytes + {32'd0, len};
            if (next_total > {32'd0, cfg_out_capacity})
                code = ST_NOSPACE;
        end
        if (code == ST_OK && last && gen_count == ALL_ONES)
            code = ST_GENOVF;

        if (code == ST_OK)
        begin
            v.src                  = uoff[31:0];
            v.dst                  = packed_bytes[31:0];
            v.span                 = len;
            span_start[spans_held] = uoff[31:0];
            span_bytes[spans_held] = len;
            spans_held++;
            packed_bytes = next_total;
            if (last)
            begin
                gen_count = gen_count + 64'd1;
                v.gen     = gen_count;
            end
        end
        else
            unit_broken = 1'b1;

        v.code = code;
        v.done = last;

        // A last entry always closes the unit.
        if (last)
        begin
            spans_held   = 0;
            packed_bytes = '0;
            unit_broken  = 1'b0;
        end
        return v;
    endfunction

    function automatic probe_row_t probe(input logic [63:0] ua, input logic [63:0] pa,
                                         input logic [31:0] len, input logic last,
                                         input logic typed, input logic [2:0] code);
        probe_row_t r;
        r.ua    = ua;
        r.pa    = pa;
        r.len   = len;
        r.last  = last;
        r.typed = typed;
        r.code  = code;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic apb_write(input logic [1:0] idx, input logic [63:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_USER_ORIGIN:  cfg_user_origin  = data;
            REG_PHYS_ORIGIN:  cfg_phys_origin  = data;
            REG_MAP_SIZE:     cfg_map_size     = data[31:0];
            REG_OUT_CAPACITY: cfg_out_capacity = data[31:0];
            default:          ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_config(input logic [63:0] ub, input logic [63:0] pb,
                                  input logic [31:0] ms, input logic [31:0] oc);
        apb_write(REG_USER_ORIGIN, ub);
        apb_write(REG_PHYS_ORIGIN, pb);
        apb_write(REG_MAP_SIZE, {32'd0, ms});
        apb_write(REG_OUT_CAPACITY, {32'd0, oc});
        settings_used++;
    endtask

    // Offer one item, in bursts with random gaps unless no_gaps is set, and record what it should give.
    task automatic send_entry(input logic [63:0] ua, input logic [63:0] pa,
                              input logic [31:0] len, input logic last,
                              input logic typed, input logic [2:0] code,
                              input bit no_gaps);
        entry_verdict_t v;
        int             gap;
        gap = 0;
        if (!no_gaps && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
        end
        if (burst_left > 0)
            burst_left--;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        user_addr  <= ua;
        phys_addr  <= pa;
        entry_len  <= len;
        last_entry <= last;
        do
            @(posedge clk);
        while (!in_ready);
        v = validate_entry(ua, pa, len, last);
        if (typed)
        begin
            v      = '0;
            v.code = code;
            v.done = last;
        end
        verdicts_due.push_back(v);
        items_sent++;
        if (last)
            units_sent++;
    endtask

    // Stop offering and wait until every result is back and the block is quiet.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random units under one register setting, mostly well-formed spans.
    task automatic run_setting(input logic [63:0] ub, input logic [63:0] pb,
                               input logic [31:0] ms, input logic [31:0] oc,
                               input bit no_gaps, input bit force_full);
        int          sent;
        int          unit_len;
        int          roll;
        bit          clean;
        logic [63:0] cursor;
        logic [63:0] off;
        logic [63:0] ua;
        logic [63:0] pa;
        logic [31:0] len;
        program_config(ub, pb, ms, oc);
        sent = 0;
        while (sent < RANDOM_ITEMS / NUM_SETTINGS)
        begin
            // A forced unit runs past the entry limit with clean spans.
            clean = force_full && sent == 0;
            if (clean)
                unit_len = MAX_SPANS + 1;
            else if ($urandom_range(0, 7) == 0)
                unit_len = $urandom_range(MAX_SPANS - 1, MAX_SPANS + 3);
            else
                unit_len = $urandom_range(1, 8);
            cursor = 64'($urandom_range(0, 64));
            for (int i = 0; i < unit_len; i++)
            begin
                roll = clean ? 0 : $urandom_range(0, 99);
                off  = cursor + $urandom_range(0, 3) * $urandom_range(0, 16);
                if ($urandom_range(0, 15) == 0)
                    len = $urandom_range(1, 32'h0000_FFFF);
                else
                    len = $urandom_range(1, 48);
                ua = ub + off;
                pa = pb + off;
                if (roll < 75)
                    cursor = off + {32'd0, len};
                else if (roll < 83)
                begin
                    // Start inside the span just placed.
                    ua = ub + cursor - 64'd1;
                    pa = pb + cursor - 64'd1;
                end
                else if (roll < 88)
                    len = 32'd0;
                else if (roll < 93)
                    pa = pb + off + $urandom_range(1, 8);
                else if (roll < 97)
                begin
                    ua  = rand64();
                    pa  = $urandom_range(0, 1) ? rand64() : ua;
                    len = $urandom;
                end
                else
                    ua = ub - $urandom_range(1, 16);
                send_entry(ua, pa, len, i == unit_len - 1, 1'b0, ST_OK, no_gaps);
                sent++;
            end
        end
        wait_idle();
    endtask

    // The receiver stalls on a rotating pattern, with one long hold-off.
    initial
    begin
        int rx_cycle;
        bit held;
        out_ready = 1'b0;
        rx_cycle  = 0;
        held      = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                case ((rx_cycle / 97) % 4)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (rx_cycle % 4) != 0;
                    default: out_ready <= $urandom_range(0, 99) < 85;
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest pending verdict.
    always @(posedge clk)
    begin
        entry_verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (verdicts_due.size() == 0)
            begin
                $error("result item with no entry pending: status %0d", status);
                fail_count++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                code_seen[want.code]++;
                check_field("status", 64'(want.code), 64'(status));
                check_field("src_offset", 64'(want.src), 64'(src_offset));
                check_field("dst_offset", 64'(want.dst), 64'(dst_offset));
                check_field("span_len", 64'(want.span), 64'(span_len));
                check_field("generation_out", want.gen, generation_out);
                check_field("unit_done", 64'(want.done), 64'(unit_done));
            end
        end
    end

    // Main sequence: reset, directed rows, random settings, drain.
    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        user_addr  = '0;
        phys_addr  = '0;
        entry_len  = '0;
        last_entry = 1'b0;

        cfg_user_origin  = '0;
        cfg_phys_origin  = '0;
        cfg_map_size     = '0;
        cfg_out_capacity = '0;
        spans_held       = 0;
        packed_bytes     = '0;
        gen_count        = '0;
        unit_broken      = 1'b0;
        fail_count       = 0;
        items_sent       = 0;
        units_sent       = 0;
        results_seen     = 0;
        settings_used    = 0;
        burst_left       = 0;
        foreach (code_seen[i])
            code_seen[i] = 0;

        // Rows run with every register at its reset value of zero.
        probe_rows[0]  = probe(64'd0, 64'd0, 32'd0, 1'b1, 1'b1, ST_ZERO);
        probe_rows[1]  = probe(ALL_ONES, ALL_ONES, 32'hFFFF_FFFF, 1'b0, 1'b1, ST_RANGE);
        probe_rows[2]  = probe(64'd0, 64'd0, 32'd1, 1'b1, 1'b1, ST_ABORTED);
        // Rows under map size 0x1000 and output capacity 0x200.
        probe_rows[3]  = probe(DIR_UB, DIR_PB, 32'h40, 1'b0, 1'b0, ST_OK);
        probe_rows[4]  = probe(DIR_UB + 'h20, DIR_PB + 'h20, 32'h40, 1'b0, 1'b1, ST_OVERLAP);
        probe_rows[5]  = probe(DIR_UB + 'h100, DIR_PB + 'h100, 32'h10, 1'b0, 1'b1, ST_ABORTED);
        probe_rows[6]  = probe(DIR_UB + 'h100, DIR_PB + 'h100, 32'h10, 1'b1, 1'b1, ST_ABORTED);
        probe_rows[7]  = probe(DIR_UB - 'h1, DIR_PB, 32'h10, 1'b1, 1'b1, ST_RANGE);
        probe_rows[8]  = probe(DIR_UB, DIR_PB - 'h1, 32'h10, 1'b1, 1'b1, ST_RANGE);
        probe_rows[9]  = probe(DIR_UB + 'h10, DIR_PB + 'h20, 32'h10, 1'b1, 1'b1, ST_RANGE);
        probe_rows[10] = probe(DIR_UB + 'hFF0, DIR_PB + 'hFF0, 32'h11, 1'b1, 1'b1, ST_RANGE);
        probe_rows[11] = probe(DIR_UB + 'hF00, DIR_PB + 'hF00, 32'h100, 1'b0, 1'b0, ST_OK);
        probe_rows[12] = probe(DIR_UB, DIR_PB, 32'h100, 1'b0, 1'b0, ST_OK);
        probe_rows[13] = probe(DIR_UB + 'h200, DIR_PB + 'h200, 32'h1, 1'b1, 1'b1, ST_NOSPACE);
        probe_rows[14] = probe(DIR_UB + 'h300, DIR_PB + 'h300, 32'h200, 1'b1, 1'b0, ST_OK);
        probe_rows[15] = probe(DIR_UB + 'h300, DIR_PB + 'h300, 32'h201, 1'b1, 1'b1, ST_NOSPACE);
        probe_rows[16] = probe(DIR_UB + 'h400, DIR_PB + 'h400, 32'h10, 1'b0, 1'b0, ST_OK);
        probe_rows[17] = probe(DIR_UB + 'h410, DIR_PB + 'h410, 32'h10, 1'b0, 1'b0, ST_OK);
        probe_rows[18] = probe(DIR_UB + 'h3F0, DIR_PB + 'h3F0, 32'h10, 1'b1, 1'b0, ST_OK);
        probe_rows[19] = probe(ALL_ONES, ALL_ONES, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_RANGE);
        probe_rows[20] = probe(64'd0, 64'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_RANGE);
        probe_rows[21] = probe(DIR_UB, DIR_PB, 32'd0, 1'b1, 1'b1, ST_ZERO);

        // Reset is held low and released on a falling edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part.
        for (int i = 0; i < NUM_PROBES; i++)
        begin
            if (i == RESET_ROWS)
            begin
                wait_idle();
                program_config(DIR_UB, DIR_PB, 32'h1000, 32'h200);
            end
            send_entry(probe_rows[i].ua, probe_rows[i].pa, probe_rows[i].len,
                       probe_rows[i].last, probe_rows[i].typed, probe_rows[i].code, 1'b0);
        end
        wait_idle();

        // Random part over several register settings, extremes among them.
        run_setting(rand64(), rand64(), 32'h2000, 32'h400, 1'b0, 1'b1);
        run_setting(64'd0, 64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        run_setting(64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_F000,
                    32'hFFFF_FFFF, 32'h300, 1'b0, 1'b0);
        run_setting(rand64(), rand64(), 32'd0, 32'd0, 1'b0, 1'b0);
        run_setting(rand64(), rand64(), $urandom_range(32'h100, 32'h4000),
                    $urandom_range(32'h40, 32'h800), 1'b0, 1'b0);
        run_setting(ALL_ONES, ALL_ONES, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
        run_setting(rand64(), rand64(), 32'h1000, 32'hFFFF_FFFF, 1'b0, 1'b1);
        run_setting(rand64(), rand64(), $urandom, $urandom, 1'b0, 1'b0);

        // Results left over would still be pending here.
        if (verdicts_due.size() != 0)
        begin
            $error("%0d expected result items never arrived", verdicts_due.size());
            fail_count++;
        end

        $display("Covered %0d entries in %0d units across %0d register settings, %0d results.",
                 items_sent, units_sent, settings_used, results_seen);
        $display("Status mix: ok %0d, zero %0d, range %0d, overlap %0d, no space %0d, %s %0d, %s %0d",
                 code_seen[ST_OK], code_seen[ST_ZERO], code_seen[ST_RANGE],
                 code_seen[ST_OVERLAP], code_seen[ST_NOSPACE], "too many",
                 code_seen[ST_TOOMANY], "aborted", code_seen[ST_ABORTED]);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
